[sv/msx_pkg.sv]
// Shared constants, instruction codes and inter-module structs of the MIPS subset core.
package msx_pkg;

  // Data memory geometry: big-endian bytes kept in four byte lanes of DATA_ROWS rows.
  localparam int unsigned DATA_BYTES = 65536;
  localparam logic [31:0] DATA_BASE  = 32'h1000_0000;
  localparam int unsigned DATA_ROWS  = (DATA_BYTES + 3) / 4;
  localparam int unsigned ROW_W      = $clog2(DATA_ROWS);
  localparam int unsigned OFF_W      = ROW_W + 2;
  localparam int unsigned CLR_W      = ROW_W + 1;
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(DATA_ROWS - 1);

  // Highest offset at which a whole word still fits, and the byte limit.
  localparam logic [31:0] WORD_LAST_OFF = 32'(DATA_BYTES - 4);
  localparam logic [31:0] BYTE_LIMIT    = 32'(DATA_BYTES);

  // General register file.
  localparam int unsigned REGS = 32;

  // Request commands.
  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // Function codes of the special opcode.
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // Memory access kinds reported with each result.
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  // Control state: clearing pass after reset, then normal operation.
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ctl_state_t;

  // One result item.
  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic [1:0]  mem_kind;
    logic [31:0] eff_address;
    logic        mem_fault;
  } result_t;

  // Data memory access from the execute stage.
  typedef struct packed {
    logic             word_wr;
    logic             byte_wr;
    logic             word_rd;
    logic [OFF_W-1:0] off;
    logic [31:0]      wdata;
  } dmem_req_t;

  // Everything the execute unit decides for one request.
  typedef struct packed {
    result_t   res;
    dmem_req_t dreq;
  } exec_t;

  // Register file write port, with a flag that marks writes eligible for bypass.
  typedef struct packed {
    logic        we;
    logic [4:0]  addr;
    logic [31:0] data;
    logic        fwd;
  } rf_wr_t;

endpackage

[sv/msx_chan_if.sv]
// Valid/ready channel interfaces for the request and result sides of the core.
interface msx_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] instr_word;
  logic [15:0] preload_offset;
  logic [7:0]  preload_byte;

  modport source (output valid, output cmd, output instr_word, output preload_offset,
                  output preload_byte, input ready);
  modport sink (input valid, input cmd, input instr_word, input preload_offset,
                input preload_byte, output ready);
endinterface

interface msx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  dest_reg;
  logic [31:0] dest_value;
  logic [1:0]  mem_kind;
  logic [31:0] eff_address;
  logic        mem_fault;

  modport source (output valid, output next_pc, output reg_written, output dest_reg,
                  output dest_value, output mem_kind, output eff_address,
                  output mem_fault, input ready);
  modport sink (input valid, input next_pc, input reg_written, input dest_reg,
                input dest_value, input mem_kind, input eff_address, input mem_fault,
                output ready);
endinterface

[sv/msx_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module msx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read first: a read of the row being written in the same cycle returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/msx_regfile.sv]
// General register file: two mirrored RAMs for two reads, plus a bypass of the last write.
module msx_regfile (
  input  logic             clk,
  input  logic             rst,
  input  logic             re,
  input  logic [4:0]       rs,
  input  logic [4:0]       rt,
  input  msx_pkg::rf_wr_t  wr,
  output logic [31:0]      a,
  output logic [31:0]      b
);

  logic [31:0] ram_a;
  logic [31:0] ram_b;
  logic [4:0]  rs_q;
  logic [4:0]  rt_q;
  logic        wb_valid;
  logic [4:0]  wb_reg;
  logic [31:0] wb_data;

  msx_ram #(.WIDTH(32), .DEPTH(msx_pkg::REGS)) u_ram_a (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (re),
    .raddr(rs),
    .rdata(ram_a)
  );

  msx_ram #(.WIDTH(32), .DEPTH(msx_pkg::REGS)) u_ram_b (
    .clk  (clk),
    .we   (wr.we),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (re),
    .raddr(rt),
    .rdata(ram_b)
  );

  // Read addresses are held with the read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rs_q <= rs;
      rt_q <= rt;
    end
  end

  // The bypass always holds the most recent write, so a match gives the current value.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (wr.we) begin
      wb_valid <= wr.fwd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      wb_reg  <= wr.addr;
      wb_data <= wr.data;
    end
  end

  // Operand select between RAM data and the bypass.
  assign a = (wb_valid && (wb_reg == rs_q)) ? wb_data : ram_a;
  assign b = (wb_valid && (wb_reg == rt_q)) ? wb_data : ram_b;

endmodule

[sv/msx_dmem.sv]
// Big-endian byte data memory built from four byte-lane RAMs, with unaligned word access.
module msx_dmem (
  input  logic                     clk,
  input  logic                     en,
  input  msx_pkg::dmem_req_t       req,
  input  logic                     clear,
  input  logic [msx_pkg::ROW_W-1:0] clear_row,
  output logic [31:0]              rdata
);

  localparam int unsigned RW = msx_pkg::ROW_W;
  localparam int unsigned OW = msx_pkg::OFF_W;

  logic [7:0] lane_rd [4];
  logic [1:0] off_q;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [1:0]    sel;
    logic [RW-1:0] row;
    logic          we;
    logic          re;
    logic [7:0]    wd;
    logic [RW-1:0] waddr;

    // Lanes below the start lane hold bytes of the following row.
    assign sel = 2'(k) - req.off[1:0];
    assign row = req.off[OW-1:2] + RW'(2'(k) < req.off[1:0]);

    assign we = clear ||
                (en && (req.word_wr || (req.byte_wr && (req.off[1:0] == 2'(k)))));
    assign re = en && req.word_rd;
    assign wd = clear ? 8'hff :
                req.byte_wr ? req.wdata[7:0] : req.wdata[{~sel, 3'b000} +: 8];
    assign waddr = clear ? clear_row : row;

    msx_ram #(.WIDTH(8), .DEPTH(msx_pkg::DATA_ROWS)) u_lane (
      .clk  (clk),
      .we   (we),
      .waddr(waddr),
      .wdata(wd),
      .re   (re),
      .raddr(row),
      .rdata(lane_rd[k])
    );
  end

  // The start lane of a load is kept to order the bytes when the data returns.
  always_ff @(posedge clk) begin
    if (en && req.word_rd) begin
      off_q <= req.off[1:0];
    end
  end

  // Most significant byte comes from the start lane.
  always_comb begin
    logic [1:0] idx;
    idx   = '0;
    rdata = '0;
    for (int j = 0; j < 4; j++) begin
      idx = off_q + 2'(j);
      rdata[8*(3-j) +: 8] = lane_rd[idx];
    end
  end

endmodule

[sv/msx_exec.sv]
// Decode and execute unit: computes result fields and data memory access for one request.
module msx_exec (
  input  logic            cmd,
  input  logic [31:0]     instr_word,
  input  logic [15:0]     preload_offset,
  input  logic [7:0]      preload_byte,
  input  logic [31:0]     pc,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output msx_pkg::exec_t  ex
);

  localparam int unsigned OW = msx_pkg::OFF_W;

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] pc_plus4;
  logic [31:0] br_target;
  logic [31:0] j_target;
  logic [31:0] ea;
  logic [31:0] word_off;
  logic [31:0] pre_off;
  logic        word_ok;
  logic        wr;
  logic [4:0]  dr;
  logic [31:0] dv;

  // Instruction fields and address arithmetic.
  assign op        = instr_word[31:26];
  assign rt        = instr_word[20:16];
  assign rd        = instr_word[15:11];
  assign sa        = instr_word[10:6];
  assign fn        = instr_word[5:0];
  assign zimm      = {16'b0, instr_word[15:0]};
  assign simm      = {{16{instr_word[15]}}, instr_word[15:0]};
  assign pc_plus4  = pc + 32'd4;
  assign br_target = pc_plus4 + {simm[29:0], 2'b00};
  assign j_target  = {pc_plus4[31:28], instr_word[25:0], 2'b00};
  assign ea        = a + simm;
  assign word_off  = ea - msx_pkg::DATA_BASE;
  assign word_ok   = word_off <= msx_pkg::WORD_LAST_OFF;
  assign pre_off   = {16'b0, preload_offset};

  // Main decoder.
  always_comb begin
    ex = '0;
    wr = 1'b0;
    dr = '0;
    dv = '0;
    ex.res.next_pc = pc_plus4;
    if (cmd == msx_pkg::CMD_PRELOAD) begin
      ex.res.next_pc     = pc;
      ex.res.eff_address = msx_pkg::DATA_BASE + pre_off;
      ex.dreq.off        = pre_off[OW-1:0];
      ex.dreq.wdata      = {24'b0, preload_byte};
      if (pre_off < msx_pkg::BYTE_LIMIT) begin
        ex.dreq.byte_wr = 1'b1;
      end else begin
        ex.res.mem_fault = 1'b1;
      end
    end else begin
      unique case (op) inside
        msx_pkg::OP_SPECIAL: begin
          dr = rd;
          unique case (fn) inside
            msx_pkg::FN_ADD, msx_pkg::FN_ADDU: begin
              wr = 1'b1;
              dv = a + b;
            end
            msx_pkg::FN_SUB, msx_pkg::FN_SUBU: begin
              wr = 1'b1;
              dv = a - b;
            end
            msx_pkg::FN_AND: begin
              wr = 1'b1;
              dv = a & b;
            end
            msx_pkg::FN_OR: begin
              wr = 1'b1;
              dv = a | b;
            end
            msx_pkg::FN_SLT: begin
              wr = 1'b1;
              dv = {31'b0, $signed(a) < $signed(b)};
            end
            msx_pkg::FN_SLTU: begin
              wr = 1'b1;
              dv = {31'b0, a < b};
            end
            msx_pkg::FN_SLL: begin
              wr = 1'b1;
              dv = b << sa;
            end
            msx_pkg::FN_SRL: begin
              wr = 1'b1;
              dv = b >> sa;
            end
            msx_pkg::FN_JR: begin
              ex.res.next_pc = a;
            end
            default: ;
          endcase
        end
        msx_pkg::OP_J: begin
          ex.res.next_pc = j_target;
        end
        msx_pkg::OP_JAL: begin
          ex.res.next_pc = j_target;
          wr = 1'b1;
          dr = 5'd31;
          dv = pc_plus4;
        end
        msx_pkg::OP_ADDI, msx_pkg::OP_ADDIU: begin
          wr = 1'b1;
          dr = rt;
          dv = ea;
        end
        msx_pkg::OP_ANDI: begin
          wr = 1'b1;
          dr = rt;
          dv = a & zimm;
        end
        msx_pkg::OP_ORI: begin
          wr = 1'b1;
          dr = rt;
          dv = a | zimm;
        end
        msx_pkg::OP_LUI: begin
          wr = 1'b1;
          dr = rt;
          dv = {instr_word[15:0], 16'b0};
        end
        msx_pkg::OP_SLTI: begin
          wr = 1'b1;
          dr = rt;
          dv = {31'b0, $signed(a) < $signed(simm)};
        end
        msx_pkg::OP_SLTIU: begin
          wr = 1'b1;
          dr = rt;
          dv = {31'b0, a < simm};
        end
        msx_pkg::OP_BEQ: begin
          if (a == b) begin
            ex.res.next_pc = br_target;
          end
        end
        msx_pkg::OP_BNE: begin
          if (a != b) begin
            ex.res.next_pc = br_target;
          end
        end
        msx_pkg::OP_LW: begin
          ex.res.mem_kind    = msx_pkg::MEM_LOAD;
          ex.res.eff_address = ea;
          ex.dreq.off        = word_off[OW-1:0];
          dr = rt;
          if (word_ok) begin
            wr = 1'b1;
            ex.dreq.word_rd = 1'b1;
          end else begin
            ex.res.mem_fault = 1'b1;
          end
        end
        msx_pkg::OP_SW: begin
          ex.res.mem_kind    = msx_pkg::MEM_STORE;
          ex.res.eff_address = ea;
          ex.dreq.off        = word_off[OW-1:0];
          ex.dreq.wdata      = b;
          if (word_ok) begin
            ex.dreq.word_wr = 1'b1;
          end else begin
            ex.res.mem_fault = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // Register zero is never written; a dropped write reports zeros.
    ex.res.reg_written = wr && (dr != 5'd0);
    ex.res.dest_reg    = ex.res.reg_written ? dr : 5'd0;
    ex.res.dest_value  = ex.res.reg_written ? dv : 32'd0;
  end

endmodule

[sv/mips_subset_execute.sv]
// Top level of the MIPS subset core: pipeline control, program counter and clearing pass.
//
// Requests arrive on in_chan: cmd 0 executes instr_word at the current program counter,
// cmd 1 writes preload_byte into data memory at preload_offset. Each request gives one
// result on out_chan: the next program counter, the register write, the memory access
// kind, its effective address and an out-of-range flag.
// A request accepted at one clock edge reads the register file at that edge and executes in
// the next cycle; its result is taken into the result register when it leaves execute.
// A new request is taken every cycle unless the result is stalled by out_chan.ready. After a
// load word the next request is not taken while the load leaves execute, because the
// byte-lane RAM read port is registered and returns the loaded value after the address.
// Register results are bypassed from the last register file write to the next reader.
// After reset the core sweeps all DATA_ROWS rows of the data memory, setting every byte to
// 0xff and the registers to zero; in_chan.ready stays low during the sweep. The result
// register is held while out_chan.ready is low; one more request can then still enter the
// execute stage and waits there.
module mips_subset_execute (
  input logic      clk,
  input logic      rst,
  msx_in_if.sink   in_chan,
  msx_out_if.source out_chan
);

  localparam int unsigned CW = msx_pkg::CLR_W;
  localparam int unsigned RW = msx_pkg::ROW_W;

  msx_pkg::ctl_state_t state;
  msx_pkg::ctl_state_t state_next;
  logic                clearing;
  logic                running;
  logic [CW-1:0]       clr_row;

  logic                in_fire;
  logic                s1_valid;
  logic                s1_adv;
  logic                s1_lw;
  logic                s1_cmd;
  logic [31:0]         s1_instr;
  logic [15:0]         s1_poff;
  logic [7:0]          s1_pbyte;
  logic [31:0]         pc;

  logic                s2_valid;
  logic                s2_ld;
  logic                s2_ld_pend;
  msx_pkg::result_t    s2_res;

  logic [31:0]         op_a;
  logic [31:0]         op_b;
  logic [31:0]         dm_rdata;
  msx_pkg::exec_t      ex;
  msx_pkg::rf_wr_t     rf_wr;

  // Control state: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      msx_pkg::ST_CLEAR: begin
        if (clr_row == msx_pkg::CLR_LAST) begin
          state_next = msx_pkg::ST_RUN;
        end
      end
      msx_pkg::ST_RUN: begin
        state_next = msx_pkg::ST_RUN;
      end
      default: state_next = msx_pkg::ST_CLEAR;
    endcase
  end

  // Control state: outputs.
  always_comb begin
    clearing = 1'b0;
    running  = 1'b0;
    unique case (state)
      msx_pkg::ST_CLEAR: clearing = 1'b1;
      msx_pkg::ST_RUN:   running  = 1'b1;
      default:           clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= msx_pkg::ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_row <= clr_row + CW'(1);
      end
    end
  end

  // Handshake: a load in execute holds off the next request until the load has left execute.
  assign s1_lw   = s1_valid && (s1_cmd == msx_pkg::CMD_EXEC) &&
                   (s1_instr[31:26] == msx_pkg::OP_LW);
  assign s1_adv  = s1_valid && (!s2_valid || out_chan.ready);
  assign in_chan.ready = running && (!s1_valid || (s1_adv && !s1_lw));
  assign in_fire = in_chan.valid && in_chan.ready;

  // Execute stage request registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd   <= in_chan.cmd;
      s1_instr <= in_chan.instr_word;
      s1_poff  <= in_chan.preload_offset;
      s1_pbyte <= in_chan.preload_byte;
    end
  end

  // Program counter moves when a request leaves execute.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (s1_adv) begin
      pc <= ex.res.next_pc;
    end
  end

  msx_regfile u_regfile (
    .clk(clk),
    .rst(rst),
    .re (in_fire),
    .rs (in_chan.instr_word[25:21]),
    .rt (in_chan.instr_word[20:16]),
    .wr (rf_wr),
    .a  (op_a),
    .b  (op_b)
  );

  msx_exec u_exec (
    .cmd           (s1_cmd),
    .instr_word    (s1_instr),
    .preload_offset(s1_poff),
    .preload_byte  (s1_pbyte),
    .pc            (pc),
    .a             (op_a),
    .b             (op_b),
    .ex            (ex)
  );

  msx_dmem u_dmem (
    .clk      (clk),
    .en       (s1_adv),
    .req      (ex.dreq),
    .clear    (clearing),
    .clear_row(clr_row[RW-1:0]),
    .rdata    (dm_rdata)
  );

  // Register file write port: clearing sweep, returning load data, or execute result.
  always_comb begin
    rf_wr = '0;
    if (clearing) begin
      rf_wr.we   = clr_row < CW'(msx_pkg::REGS);
      rf_wr.addr = clr_row[4:0];
    end else if (s2_ld_pend) begin
      rf_wr.we   = 1'b1;
      rf_wr.addr = s2_res.dest_reg;
      rf_wr.data = dm_rdata;
      rf_wr.fwd  = 1'b1;
    end else if (s1_adv && ex.res.reg_written && (ex.res.mem_kind != msx_pkg::MEM_LOAD)) begin
      rf_wr.we   = 1'b1;
      rf_wr.addr = ex.res.dest_reg;
      rf_wr.data = ex.res.dest_value;
      rf_wr.fwd  = 1'b1;
    end
  end

  // Result register; a load's value comes straight from the held RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      s2_ld_pend <= 1'b0;
    end else begin
      s2_ld_pend <= s1_adv && ex.res.reg_written && (ex.res.mem_kind == msx_pkg::MEM_LOAD);
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (out_chan.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_res <= ex.res;
      s2_ld  <= ex.res.reg_written && (ex.res.mem_kind == msx_pkg::MEM_LOAD);
    end
  end

  assign out_chan.valid       = s2_valid;
  assign out_chan.next_pc     = s2_res.next_pc;
  assign out_chan.reg_written = s2_res.reg_written;
  assign out_chan.dest_reg    = s2_res.dest_reg;
  assign out_chan.dest_value  = s2_ld ? dm_rdata : s2_res.dest_value;
  assign out_chan.mem_kind    = s2_res.mem_kind;
  assign out_chan.eff_address = s2_res.eff_address;
  assign out_chan.mem_fault   = s2_res.mem_fault;

  // The load write-back never meets a request in execute on the register write port.
  a_ld_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s2_ld_pend |-> !s1_valid)
    else $error("load write-back overlaps a request in execute");

  // A pending load write-back belongs to the result currently held.
  a_ld_in_result: assert property (@(posedge clk) disable iff (rst)
    s2_ld_pend |-> (s2_valid && s2_ld))
    else $error("load write-back without a held load result");

  // No request is in flight while the memories are being cleared.
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_valid && !s2_valid))
    else $error("request in flight during clearing pass");

  // The program counter only moves when a request leaves execute.
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(pc))
    else $error("program counter changed without a request");

endmodule
